FILE: src/sm3_pkg.sv
package sm3_pkg;

    // round constants
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;

    // eight 32-bit words: chaining value or working registers a..h (index 0 = a)
    typedef logic [7:0][31:0] t_words;

    // standard initial value
    localparam t_words SM3_IV = '{
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    // rotate left, count taken mod 32
    function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
        logic [5:0] rn;
        rn = 6'd32 - {1'b0, n};
        rotl32 = (x << n) | (x >> rn);
    endfunction

    function automatic logic [31:0] perm0(logic [31:0] x);
        perm0 = x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(logic [31:0] x);
        perm1 = x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

FILE: src/sm3_msg_if.sv
interface sm3_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic        first_block;

    modport source (output valid, output message_word, output first_block, input ready);
    modport sink   (input valid, input message_word, input first_block, output ready);
endinterface

FILE: src/sm3_dig_if.sv
interface sm3_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

FILE: src/sm3_sched.sv
module sm3_sched
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_word,
    input  logic        i_adv,
    output logic [31:0] o_wj,
    output logic [31:0] o_wpj
);

    // sliding window: r_win[0] holds W[j], r_win[15] holds W[j+15]
    logic [15:0][31:0] r_win;
    logic [15:0][31:0] n_win;
    logic [31:0]       exp_word;

    // next schedule word W[j+16]
    assign exp_word = perm1(r_win[0] ^ r_win[7] ^ rotl32(r_win[13], 5'd15))
                    ^ rotl32(r_win[3], 5'd7) ^ r_win[10];

    // shift in either a message word or an expanded word
    always_comb begin
        n_win = r_win;
        if (i_load) begin
            n_win = {i_word, r_win[15:1]};
        end else if (i_adv) begin
            n_win = {exp_word, r_win[15:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_wj  = r_win[0];
    assign o_wpj = r_win[0] ^ r_win[4];

endmodule

FILE: src/sm3_round.sv
module sm3_round
    import sm3_pkg::*;
(
    input  t_words      i_v,
    input  logic [5:0]  i_round,
    input  logic [31:0] i_wj,
    input  logic [31:0] i_wpj,
    output t_words      o_v
);

    logic        early;
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;

    always_comb begin
        a = i_v[0]; b = i_v[1]; c = i_v[2]; d = i_v[3];
        e = i_v[4]; f = i_v[5]; g = i_v[6]; h = i_v[7];
        early = (i_round[5:4] == 2'b00);
        tj  = early ? T_LOW : T_HIGH;
        a12 = rotl32(a, 5'd12);
        ss1 = rotl32(a12 + e + rotl32(tj, i_round[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        // boolean functions differ between the first 16 rounds and the rest
        if (early) begin
            ffv = a ^ b ^ c;
            ggv = e ^ f ^ g;
        end else begin
            ffv = (a & b) | (a & c) | (b & c);
            ggv = (e & f) | (~e & g);
        end
        tt1 = ffv + d + ss2 + i_wpj;
        tt2 = ggv + h + ss1 + i_wj;
        o_v[0] = tt1;
        o_v[1] = a;
        o_v[2] = rotl32(b, 5'd9);
        o_v[3] = c;
        o_v[4] = perm0(tt2);
        o_v[5] = e;
        o_v[6] = rotl32(f, 5'd19);
        o_v[7] = g;
    end

endmodule

FILE: src/sm3_block_compression_core.sv
// channel   dir  payload                          transfer when
// i_msg     in   message_word[31:0], first_block  i_msg.valid & i_msg.ready
// o_dig     out  digest_word[31:0], last_word     o_dig.valid & o_dig.ready
//
// words 0..14 of a block fill the schedule; the 16th word starts 64 rounds,
// one round per cycle through a single shared round unit
// the eight chaining words follow, one per cycle while o_dig.ready is high
// input is held off during rounds and while digest words are delivered
// i_rst_n (synchronous) restores the IV and clears the word count
module sm3_block_compression_core
    import sm3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    sm3_msg_if.sink   i_msg,
    sm3_dig_if.source o_dig
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    t_words     r_cv, n_cv;
    t_words     r_work, n_work;

    logic        in_xfer, out_xfer, adv;
    logic [3:0]  eff_cnt;
    logic [31:0] wj, wpj;
    t_words      round_v;

    assign in_xfer  = i_msg.valid && i_msg.ready;
    assign out_xfer = o_dig.valid && o_dig.ready;
    assign adv      = (r_state == S_ROUND);

    // a restart word is always word 0 of a fresh block
    assign eff_cnt = i_msg.first_block ? 4'd0 : r_cnt;

    sm3_sched u_sched (
        .i_clk  (i_clk),
        .i_load (in_xfer),
        .i_word (i_msg.message_word),
        .i_adv  (adv),
        .o_wj   (wj),
        .o_wpj  (wpj)
    );

    sm3_round u_round (
        .i_v     (r_work),
        .i_round (r_round),
        .i_wj    (wj),
        .i_wpj   (wpj),
        .o_v     (round_v)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_round = r_round;
        n_idx   = r_idx;
        n_cv    = r_cv;
        n_work  = r_work;
        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (i_msg.first_block) begin
                        n_cv = SM3_IV;
                    end
                    n_cnt = eff_cnt + 4'd1;
                    if (eff_cnt == 4'd15) begin
                        n_work  = r_cv;
                        n_round = '0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                n_work  = round_v;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_cv    = r_cv ^ round_v;
                    n_idx   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_cv    <= SM3_IV;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_cv    <= n_cv;
        end
    end

    // working registers a..h
    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign i_msg.ready       = (r_state == S_LOAD);
    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_word = r_cv[r_idx];
    assign o_dig.last_word   = (r_idx == 3'd7);

endmodule

FILE: src/sm3_checker.sv
module sm3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic        i_out_last
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
                                         && $stable(i_out_last))
        else $error("digest word changed while stalled");

    // input and output never transfer side by side
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while digest pending");

    // a message word never yields a digest word in the next cycle
    a_rounds_take_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("digest appeared right after input transfer");

    // the last word closes the burst
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid && i_in_ready)
        else $error("output continued after last word");

endmodule

bind sm3_block_compression_core sm3_checker u_sm3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_msg.valid),
    .i_in_ready  (i_msg.ready),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_word  (o_dig.digest_word),
    .i_out_last  (o_dig.last_word)
);

FILE: verif/testbench.sv
module testbench;

    // standard initial chaining value, V0 in the top word
    localparam logic [255:0] INIT_CHAIN = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };
    localparam logic [31:0] ROUND_CONST_EARLY = 32'h79CC4519;
    localparam logic [31:0] ROUND_CONST_LATE  = 32'h7A879D8A;
    localparam int          WORDS_PER_BLOCK   = 16;
    localparam int          QUIET_LIMIT       = 2000;
    localparam int          TAIL_CYCLES       = 200;
    localparam int          HOLD_CYCLES       = 300;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } digest_item_t;

    // predictor of the chaining value and store of pending digest words
    class sm3_digest_scoreboard;
        logic [31:0]  chain_words [8];
        logic [31:0]  block_words [16];
        int unsigned  fill_count;
        digest_item_t pending_digest [$];
        int unsigned  errors;
        int unsigned  words_taken;
        int unsigned  blocks_done;
        int unsigned  digests_checked;
        int unsigned  mid_block_restarts;

        function new();
            load_init();
            fill_count = 0;
            errors = 0;
            words_taken = 0;
            blocks_done = 0;
            digests_checked = 0;
            mid_block_restarts = 0;
        endfunction

        function void load_init();
            for (int k = 0; k < 8; k++)
                chain_words[k] = INIT_CHAIN[255 - 32 * k -: 32];
        endfunction

        // rotate left, count mod 32, zero count leaves the word alone
        function logic [31:0] rol(logic [31:0] x, int unsigned n);
            int unsigned m;
            m = n % 32;
            if (m == 0)
                return x;
            return (x << m) | (x >> (32 - m));
        endfunction

        function logic [31:0] mix_p0(logic [31:0] x);
            return x ^ rol(x, 9) ^ rol(x, 17);
        endfunction

        function logic [31:0] mix_p1(logic [31:0] x);
            return x ^ rol(x, 15) ^ rol(x, 23);
        endfunction

        // schedule expansion, 64 rounds, xor into the chaining value
        function void compress_block();
            logic [31:0] w [68];
            logic [31:0] wx [64];
            logic [31:0] a, b, c, d, e, f, g, h;
            logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
            for (int j = 0; j < 16; j++)
                w[j] = block_words[j];
            for (int j = 16; j < 68; j++)
                w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
            for (int j = 0; j < 64; j++)
                wx[j] = w[j] ^ w[j+4];
            a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
            e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
            for (int j = 0; j < 64; j++) begin
                tj  = (j < 16) ? ROUND_CONST_EARLY : ROUND_CONST_LATE;
                a12 = rol(a, 12);
                ss1 = rol(a12 + e + rol(tj, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16) begin
                    ffv = a ^ b ^ c;
                    ggv = e ^ f ^ g;
                end else begin
                    ffv = (a & b) | (a & c) | (b & c);
                    ggv = (e & f) | (~e & g);
                end
                tt1 = ffv + d + ss2 + wx[j];
                tt2 = ggv + h + ss1 + w[j];
                d = c;
                c = rol(b, 9);
                b = a;
                a = tt1;
                h = g;
                g = rol(f, 19);
                f = e;
                e = mix_p0(tt2);
            end
            chain_words[0] ^= a; chain_words[1] ^= b; chain_words[2] ^= c; chain_words[3] ^= d;
            chain_words[4] ^= e; chain_words[5] ^= f; chain_words[6] ^= g; chain_words[7] ^= h;
        endfunction

        // one accepted message word
        function void note_word(logic [31:0] word, logic first);
            digest_item_t item;
            if (first) begin
                if (fill_count != 0)
                    mid_block_restarts++;
                load_init();
                fill_count = 0;
            end
            block_words[fill_count] = word;
            fill_count++;
            words_taken++;
            if (fill_count == WORDS_PER_BLOCK) begin
                fill_count = 0;
                compress_block();
                blocks_done++;
                for (int k = 0; k < 8; k++) begin
                    item.digest_word = chain_words[k];
                    item.last_word   = (k == 7);
                    pending_digest.push_back(item);
                end
            end
        endfunction

        // one accepted digest word against the oldest pending one
        function void check_digest(logic [31:0] word, logic last);
            digest_item_t want;
            if (pending_digest.size() == 0) begin
                $error("unexpected digest transfer: digest_word %h last_word %b", word, last);
                errors++;
                return;
            end
            want = pending_digest.pop_front();
            digests_checked++;
            if (word !== want.digest_word) begin
                $error("digest_word: expected %h, actual %h", want.digest_word, word);
                errors++;
            end
            if (last !== want.last_word) begin
                $error("last_word: expected %b, actual %b", want.last_word, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sm3_msg_if msg_bus ();
    sm3_dig_if dig_bus ();

    sm3_block_compression_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_bus),
        .o_dig   (dig_bus)
    );

    sm3_digest_scoreboard sb;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    logic        hold_digest;
    int unsigned quiet_cycles;
    int unsigned words_sent;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off
    always @(negedge i_clk) begin
        if (hold_digest)
            dig_bus.ready <= 1'b0;
        else
            dig_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // digest checking on every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && dig_bus.valid && dig_bus.ready)
            sb.check_digest(dig_bus.digest_word, dig_bus.last_word);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_bus.valid && msg_bus.ready) || (dig_bus.valid && dig_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("[sm3_block_compression_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, optional idle cycles first, return at a falling edge
    task automatic send_word(input logic [31:0] word, input logic first);
        while ($urandom_range(99) < sender_idle_pct) begin
            msg_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        msg_bus.valid        <= 1'b1;
        msg_bus.message_word <= word;
        msg_bus.first_block  <= first;
        @(posedge i_clk);
        while (!msg_bus.ready)
            @(posedge i_clk);
        sb.note_word(word, first);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        msg_bus.valid <= 1'b0;
    endtask

    task automatic wait_for_digests();
        while (sb.pending_digest.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
        @(posedge i_clk);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        @(negedge i_clk);
    endtask

    task automatic hold_receiver(input int unsigned cycles);
        @(posedge i_clk);
        hold_digest = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_digest = 1'b0;
    endtask

    // word content biased toward the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom();
        endcase
    endfunction

    // messages of random length; some cut off mid-block,
    // some continuing the previous chain without the restart flag
    task automatic run_messages(input int unsigned count);
        int unsigned target;
        int unsigned blocks;
        int unsigned length;
        logic        flag;
        target = words_sent + count;
        while (words_sent < target) begin
            blocks = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            length = blocks * WORDS_PER_BLOCK;
            if ($urandom_range(9) == 0)
                length = $urandom_range(1, WORDS_PER_BLOCK - 1);
            flag = ($urandom_range(6) != 0);
            for (int unsigned n = 0; n < length && words_sent < target; n++)
                send_word(pick_word(), (n == 0) ? flag : 1'b0);
        end
        stop_sending();
    endtask

    // main sequence
    initial begin
        sb = new();
        i_rst_n              = 1'b0;
        msg_bus.valid        = 1'b0;
        msg_bus.message_word = '0;
        msg_bus.first_block  = 1'b0;
        hold_digest          = 1'b0;
        sender_idle_pct      = 0;
        receiver_stall_pct   = 0;
        words_sent           = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // partial block from the reset value, then a restart in mid-block
        send_word(32'h0000_0000, 1'b0);
        repeat (4) send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 15; i++) begin
            case (i % 4)
                0: send_word(32'h0000_0000, 1'b0);
                1: send_word(32'hFFFF_FFFF, 1'b0);
                2: send_word(32'h8000_0001, 1'b0);
                default: send_word(32'h7FFF_FFFE, 1'b0);
            endcase
        end
        stop_sending();
        wait_for_digests();

        // random traffic under each idling pattern
        set_idling(0, 0);
        run_messages(85);
        wait_for_digests();
        set_idling(70, 0);
        run_messages(80);
        wait_for_digests();
        set_idling(0, 70);
        run_messages(85);
        wait_for_digests();
        set_idling(18, 18);
        run_messages(85);
        wait_for_digests();

        // long receiver hold-off while words keep coming, then drain
        set_idling(0, 0);
        fork
            hold_receiver(HOLD_CYCLES);
            run_messages(48);
        join
        wait_for_digests();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_digest.size() != 0) begin
            $error("%0d digest words never arrived", sb.pending_digest.size());
            sb.errors++;
        end
        $display("covered %0d message words, %0d blocks, %0d digest words checked",
                 sb.words_taken, sb.blocks_done, sb.digests_checked);
        $display("including %0d mid-block restarts, under five idling patterns",
                 sb.mid_block_restarts);
        if (sb.errors == 0)
            $display("[sm3_block_compression_core] OK");
        else
            $display("[sm3_block_compression_core] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/sm3_pkg.sv
src/sm3_msg_if.sv
src/sm3_dig_if.sv
src/sm3_sched.sv
src/sm3_round.sv
src/sm3_block_compression_core.sv
src/sm3_checker.sv
verif/testbench.sv
